[src/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
// No dependencies; imported by spq_cell and stable_priority_queue.
package spq_pkg;

   localparam int SPQ_CAPACITY = 16;
   localparam int SPQ_VAL_W    = 32;
   localparam int SPQ_PRI_W    = 8;

   localparam logic SPQ_CMD_ENQ = 1'b0;
   localparam logic SPQ_CMD_DEQ = 1'b1;

   typedef enum logic [1:0] {
      SPQ_ST_OK    = 2'd0,
      SPQ_ST_EMPTY = 2'd1,
      SPQ_ST_FULL  = 2'd2
   } spq_status_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic                 enq;
      logic                 deq;
      logic [SPQ_PRI_W-1:0] pri;
      logic [SPQ_VAL_W-1:0] val;
   } spq_ctrl_type;

endpackage

[src/spq_cell.sv]
// One slot of the sorted register chain: holds a priority and a value.
// Depends on spq_pkg.
module spq_cell (
   input  logic                           clock,
   input  spq_pkg::spq_ctrl_type          ctrl,
   input  logic                           occupied,
   input  logic                           ge_left,
   input  logic [spq_pkg::SPQ_PRI_W-1:0]  left_pri,
   input  logic [spq_pkg::SPQ_VAL_W-1:0]  left_val,
   input  logic [spq_pkg::SPQ_PRI_W-1:0]  right_pri,
   input  logic [spq_pkg::SPQ_VAL_W-1:0]  right_val,
   output logic                           ge_out,
   output logic [spq_pkg::SPQ_PRI_W-1:0]  pri_out,
   output logic [spq_pkg::SPQ_VAL_W-1:0]  val_out
);
   import spq_pkg::*;

   logic [SPQ_PRI_W-1:0] pri_ff, pri_in;
   logic [SPQ_VAL_W-1:0] val_ff, val_in;

   // new entry goes behind this one when priorities tie
   assign ge_out  = occupied && (pri_ff >= ctrl.pri);
   assign pri_out = pri_ff;
   assign val_out = val_ff;

   always_comb begin
      pri_in = pri_ff;
      val_in = val_ff;
      if (ctrl.enq && !ge_out) begin
         if (ge_left) begin
            pri_in = ctrl.pri;
            val_in = ctrl.val;
         end else begin
            pri_in = left_pri;
            val_in = left_val;
         end
      end else if (ctrl.deq) begin
         pri_in = right_pri;
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      pri_ff <= pri_in;
      val_ff <= val_in;
   end

endmodule

[src/stable_priority_queue.sv]
// Stable priority queue: top level with the cell chain and stream handshakes.
// Depends on spq_pkg and spq_cell.
//
// Usage: each req transaction carries a command in req_tuser (0 enqueue,
// 1 dequeue) and the value and priority in req_tdata. Every request gives
// exactly one rsp transaction: the dequeued value in rsp_tdata, the status
// and the now-empty flag in rsp_tuser.
// The store is a row of CAPACITY cells kept sorted by priority, head in
// cell 0. On enqueue every cell compares its priority with the new one at
// once and either holds, takes the new entry or takes its left neighbour;
// on dequeue every cell takes its right neighbour. Equal priorities keep
// arrival order.
// Responses are registered, valid in the cycle after acceptance; one request
// per cycle is taken while the response side keeps up. A stalled rsp_tready
// holds the response register and req_tready drops until it is taken.
// Reset empties the queue at once; no clearing pass is needed.
// Enqueue on a full queue is dropped with status 2; dequeue on an empty
// queue returns 0 with status 1.
module stable_priority_queue #(
   parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] item_value, [39:32] item_priority
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_value
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] now_empty
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SPQ_VAL_W-1:0] rsp_value_ff, rsp_value_in;
   spq_status_type       rsp_status_ff, rsp_status_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   spq_ctrl_type         ctrl;
   logic                 accept, is_full, is_empty;

   logic [CAPACITY-1:0]  ge;
   logic [SPQ_PRI_W-1:0] cell_pri [CAPACITY];
   logic [SPQ_VAL_W-1:0] cell_val [CAPACITY];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   assign ctrl.enq = accept && (req_tuser == SPQ_CMD_ENQ) && !is_full;
   assign ctrl.deq = accept && (req_tuser == SPQ_CMD_DEQ) && !is_empty;
   assign ctrl.pri = req_tdata[39:32];
   assign ctrl.val = req_tdata[31:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 occ;
      logic                 ge_l;
      logic [SPQ_PRI_W-1:0] l_pri, r_pri;
      logic [SPQ_VAL_W-1:0] l_val, r_val;

      assign occ = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign ge_l  = 1'b1;
         assign l_pri = ctrl.pri;
         assign l_val = ctrl.val;
      end else begin : g_body
         assign ge_l  = ge[i-1];
         assign l_pri = cell_pri[i-1];
         assign l_val = cell_val[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_pri = cell_pri[i];
         assign r_val = cell_val[i];
      end else begin : g_next
         assign r_pri = cell_pri[i+1];
         assign r_val = cell_val[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occ),
         .ge_left   (ge_l),
         .left_pri  (l_pri),
         .left_val  (l_val),
         .right_pri (r_pri),
         .right_val (r_val),
         .ge_out    (ge[i]),
         .pri_out   (cell_pri[i]),
         .val_out   (cell_val[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (ctrl.enq) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.deq) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = SPQ_ST_OK;
         rsp_empty_in  = (count_in == '0);
         if (req_tuser == SPQ_CMD_ENQ) begin
            if (is_full) begin
               rsp_status_in = SPQ_ST_FULL;
            end
         end else if (is_empty) begin
            rsp_status_in = SPQ_ST_EMPTY;
         end else begin
            rsp_value_in = cell_val[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_empty_ff, rsp_status_ff};

endmodule

[tb/sv/tb_stable_priority_queue.sv]
// Self-checking testbench for stable_priority_queue: directed, random, stall and full-rate tests.
// Commands are predicted by a behavioural sorted list and checked against each response.
// Depends on spq_pkg and the stable_priority_queue RTL.
`timescale 1ns / 1ps

module tb_stable_priority_queue;
   import spq_pkg::*;

   localparam int CAP         = SPQ_CAPACITY;
   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_CYCLES = 90;

   typedef struct packed {
      logic [31:0]    value;
      spq_status_type status;
      logic           now_empty;
   } pq_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   // sorted copy of the store, head at index 0
   logic [31:0] held_value [CAP];
   logic [7:0]  held_pri [CAP];
   int          held_count;

   pq_result_type pending_results[$];

   int  error_count;
   int  stall_cycles;
   int  commands_sent;
   int  enq_count;
   int  deq_count;
   int  full_drops;
   int  empty_deqs;
   bit  send_idle_en;
   bit  recv_idle_en;
   bit  hold_request;

   stable_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic pq_result_type predict_command(input logic cmd, input logic [31:0] val,
                                                     input logic [7:0] pri);
      pq_result_type r;
      int            pos;
      r.value     = '0;
      r.status    = SPQ_ST_OK;
      if (cmd == SPQ_CMD_ENQ) begin
         enq_count++;
         if (held_count >= CAP) begin
            r.status = SPQ_ST_FULL;
            full_drops++;
         end else begin
            pos = 0;
            while (pos < held_count && held_pri[pos] >= pri) pos++;
            for (int i = held_count; i > pos; i--) begin
               held_value[i] = held_value[i-1];
               held_pri[i]   = held_pri[i-1];
            end
            held_value[pos] = val;
            held_pri[pos]   = pri;
            held_count++;
         end
      end else begin
         deq_count++;
         if (held_count == 0) begin
            r.status = SPQ_ST_EMPTY;
            empty_deqs++;
         end else begin
            r.value = held_value[0];
            for (int i = 1; i < held_count; i++) begin
               held_value[i-1] = held_value[i];
               held_pri[i-1]   = held_pri[i];
            end
            held_count--;
         end
      end
      r.now_empty = (held_count == 0);
      return r;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic send_command(input logic cmd, input logic [31:0] val, input logic [7:0] pri);
      if (send_idle_en && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pri, val};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_command(cmd, val, pri));
      commands_sent++;
   endtask

   task automatic test_dequeue_empty();
      send_command(SPQ_CMD_DEQ, 32'hFFFF_FFFF, 8'hFF);
   endtask

   // fill with ties and extremes, overflow twice, drain past empty
   task automatic test_fill_overflow_drain();
      localparam logic [127:0] FILL_PRI = {8'd200, 8'd64, 8'd64, 8'd128, 8'd255, 8'd0,
                                           8'd1, 8'd254, 8'd128, 8'd7, 8'd0, 8'd255,
                                           8'd128, 8'd128, 8'd0, 8'd255};
      logic [31:0] val;
      for (int i = 0; i < CAP; i++) begin
         case (i)
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = 32'h0000_0000;
            3:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
         endcase
         send_command(SPQ_CMD_ENQ, val, FILL_PRI[i*8 +: 8]);
      end
      send_command(SPQ_CMD_ENQ, 32'h1234_5678, 8'd255);
      send_command(SPQ_CMD_ENQ, 32'h8765_4321, 8'd0);
      for (int i = 0; i <= CAP; i++) send_command(SPQ_CMD_DEQ, $urandom, 8'($urandom));
   endtask

   task automatic send_random(input int enq_pct, input int pri_mode);
      logic [7:0] pri;
      case (pri_mode)
         0:       pri = 8'($urandom);
         1:       pri = 8'($urandom_range(0, 3));
         default: pri = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      endcase
      if ($urandom_range(0, 99) < enq_pct) send_command(SPQ_CMD_ENQ, $urandom, pri);
      else send_command(SPQ_CMD_DEQ, $urandom, 8'($urandom));
   endtask

   // runs with a drifting enqueue bias so the fill level sweeps empty to full
   task automatic test_random_traffic(input int n_items);
      int start;
      int run_len;
      int enq_pct;
      int pri_mode;
      start = commands_sent;
      while (commands_sent - start < n_items) begin
         run_len  = $urandom_range(20, 60);
         enq_pct  = 10 + 20 * $urandom_range(0, 4);
         pri_mode = $urandom_range(0, 2);
         repeat (run_len) send_random(enq_pct, pri_mode);
      end
   endtask

   task automatic test_output_stall();
      hold_request = 1'b1;
      repeat (30) send_random(70, 0);
   endtask

   task automatic test_full_rate(input int n_items);
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      repeat (n_items) send_random(50, $urandom_range(0, 2));
   endtask

   // receiver: random stalls, plus one long hold on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      pq_result_type got;
      pq_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value     = rsp_tdata;
         got.status    = spq_status_type'(rsp_tuser[1:0]);
         got.now_empty = rsp_tuser[2];
         if (pending_results.size() == 0) begin
            note_error($sformatf("unexpected response value=%h status=%0d empty=%b",
                                 got.value, got.status, got.now_empty));
         end else begin
            want = pending_results.pop_front();
            if (got.value !== want.value || got.status !== want.status ||
                got.now_empty !== want.now_empty)
               note_error($sformatf({"exp value=%h status=%0d empty=%b, ",
                                     "got value=%h status=%0d empty=%b"},
                                    want.value, want.status, want.now_empty,
                                    got.value, got.status, got.now_empty));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int waited;
      error_count   = 0;
      stall_cycles  = 0;
      commands_sent = 0;
      enq_count     = 0;
      deq_count     = 0;
      full_drops    = 0;
      empty_deqs    = 0;
      held_count    = 0;
      send_idle_en  = 1'b1;
      recv_idle_en  = 1'b1;
      hold_request  = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= SPQ_CMD_ENQ;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_dequeue_empty();
      test_fill_overflow_drain();
      test_random_traffic(1000);
      test_output_stall();
      test_full_rate(120);
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      if (pending_results.size() != 0)
         note_error($sformatf("%0d responses never arrived", pending_results.size()));

      $display("Ran %0d commands: %0d enqueues (%0d dropped on full), %0d dequeues %s",
               commands_sent, enq_count, full_drops, deq_count,
               $sformatf("(%0d on empty),", empty_deqs));
      $display("with random stalls on both sides, one long output hold and a full-rate tail.");
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
